/* src/lcd_scanline_mode_timer_unit_defines.svh */
// Assertion macros for the scanline mode timer.
// Each check is clocked on the rising edge and is idle while reset is held.
`ifndef LCD_SCANLINE_MODE_TIMER_UNIT_DEFINES_SVH
`define LCD_SCANLINE_MODE_TIMER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LCDSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcdsm: same-cycle check failed");
`define LCDSM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcdsm: next-cycle check failed");
`else
`define LCDSM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LCDSM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/lcdsm_pkg.sv */
package lcdsm_pkg;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int MODE_W = 2;
    localparam int LINE_W = 8;
    localparam int DOT_W  = 9;

    // default timing
    localparam int DEF_LINE_DOTS      = 456;
    localparam int DEF_SCAN_DOTS      = 80;
    localparam int DEF_DRAW_DOTS      = 172;
    localparam int DEF_DRAW_LEAD_DOTS = 12;
    localparam int DEF_VISIBLE_LINES  = 144;
    localparam int DEF_BLANK_LINES    = 10;

    // control / status bit positions
    localparam int CTRL_ENABLE = 7;
    localparam int STAT_LYC_FLAG = 2;
    localparam int STAT_HBL_EN   = 3;
    localparam int STAT_VBL_EN   = 4;
    localparam int STAT_OAM_EN   = 5;
    localparam int STAT_LYC_EN   = 6;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_CTRL = 2'd1,
        OP_STAT = 2'd2,
        OP_LYC  = 2'd3
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode_now;
        logic [LINE_W-1:0] line_now;
        logic [BYTE_W-1:0] status_byte;
        logic              stat_irq;
        logic              vblank_irq;
        logic              frame_done;
        logic              pixel_valid;
        logic [BYTE_W-1:0] pixel_x;
        logic [BYTE_W-1:0] pixel_y;
    } result_t;

endpackage

/* src/lcdsm_cmd_if.sv */
interface lcdsm_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [lcdsm_pkg::OP_W-1:0]   opcode;
    logic [lcdsm_pkg::BYTE_W-1:0] write_data;

    modport source (output valid, output opcode, output write_data, input ready);
    modport sink   (input valid, input opcode, input write_data, output ready);
endinterface

/* src/lcdsm_res_if.sv */
interface lcdsm_res_if;
    logic                        valid;
    logic                        ready;
    logic [lcdsm_pkg::MODE_W-1:0] mode_now;
    logic [lcdsm_pkg::LINE_W-1:0] line_now;
    logic [lcdsm_pkg::BYTE_W-1:0] status_byte;
    logic                        stat_irq;
    logic                        vblank_irq;
    logic                        frame_done;
    logic                        pixel_valid;
    logic [lcdsm_pkg::BYTE_W-1:0] pixel_x;
    logic [lcdsm_pkg::BYTE_W-1:0] pixel_y;

    modport source (
        output valid, output mode_now, output line_now, output status_byte,
        output stat_irq, output vblank_irq, output frame_done,
        output pixel_valid, output pixel_x, output pixel_y,
        input ready
    );
    modport sink (
        input valid, input mode_now, input line_now, input status_byte,
        input stat_irq, input vblank_irq, input frame_done,
        input pixel_valid, input pixel_x, input pixel_y,
        output ready
    );
endinterface

/* src/lcdsm_core.sv */
// Timer state and its combinational next-state logic.
module lcdsm_core #(
    parameter int LINE_DOTS      = lcdsm_pkg::DEF_LINE_DOTS,
    parameter int SCAN_DOTS      = lcdsm_pkg::DEF_SCAN_DOTS,
    parameter int DRAW_DOTS      = lcdsm_pkg::DEF_DRAW_DOTS,
    parameter int DRAW_LEAD_DOTS = lcdsm_pkg::DEF_DRAW_LEAD_DOTS,
    parameter int VISIBLE_LINES  = lcdsm_pkg::DEF_VISIBLE_LINES,
    parameter int BLANK_LINES    = lcdsm_pkg::DEF_BLANK_LINES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic [lcdsm_pkg::OP_W-1:0]   opcode,
    input  logic [lcdsm_pkg::BYTE_W-1:0] write_data,
    output lcdsm_pkg::result_t           res
);

    localparam int LINE_W = lcdsm_pkg::LINE_W;
    localparam int BYTE_W = lcdsm_pkg::BYTE_W;
    localparam int DOT_W  = lcdsm_pkg::DOT_W;
    // one spare bit so thresholds past the dot wrap are never met
    localparam int CMP_W  = DOT_W + 1;

    localparam logic [CMP_W-1:0]  LINE_END_T = CMP_W'(LINE_DOTS);
    localparam logic [CMP_W-1:0]  SCAN_END_T = CMP_W'(SCAN_DOTS);
    localparam logic [CMP_W-1:0]  DRAW_END_T = CMP_W'(SCAN_DOTS + DRAW_DOTS);
    localparam logic [CMP_W-1:0]  PIX_T      = CMP_W'(SCAN_DOTS + DRAW_LEAD_DOTS);
    localparam logic [LINE_W-1:0] LAST_LINE  = LINE_W'(VISIBLE_LINES + BLANK_LINES - 1);
    localparam logic [LINE_W-1:0] VBL_LINE   = LINE_W'(VISIBLE_LINES);

    logic                running_reg, running_next;
    lcdsm_pkg::mode_t    mode_reg, mode_next;
    logic [DOT_W-1:0]    dot_reg, dot_next;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic [BYTE_W-1:0]   ctrl_reg, ctrl_next;
    logic [BYTE_W-1:0]   stat_reg, stat_next;
    logic [BYTE_W-1:0]   cmp_reg, cmp_next;
    logic                level_reg, level_next;

    logic [DOT_W-1:0]    dot_inc;
    logic [CMP_W-1:0]    dot_ext;
    logic [CMP_W-1:0]    pix_diff;
    logic [LINE_W-1:0]   line_wrap;
    logic                refresh;
    logic                lvl;

    function automatic logic level_of(
        input logic [BYTE_W-1:0] st,
        input logic [BYTE_W-1:0] cmp,
        input logic [LINE_W-1:0] line,
        input lcdsm_pkg::mode_t  m
    );
        logic l;
        l = st[lcdsm_pkg::STAT_LYC_EN] && (cmp == line);
        unique case (m)
            lcdsm_pkg::MODE_HBLANK: l = l | st[lcdsm_pkg::STAT_HBL_EN];
            lcdsm_pkg::MODE_VBLANK: l = l | st[lcdsm_pkg::STAT_VBL_EN];
            lcdsm_pkg::MODE_OAM:    l = l | st[lcdsm_pkg::STAT_OAM_EN];
            lcdsm_pkg::MODE_DRAW:   l = l;
            default:                l = l;
        endcase
        return l;
    endfunction

    assign dot_inc   = dot_reg + DOT_W'(1);
    assign dot_ext   = {1'b0, dot_inc};
    assign pix_diff  = dot_ext - PIX_T;
    assign line_wrap = (line_reg == LAST_LINE) ? '0 : line_reg + LINE_W'(1);

    always_comb
    begin
        running_next = running_reg;
        mode_next    = mode_reg;
        dot_next     = dot_reg;
        line_next    = line_reg;
        ctrl_next    = ctrl_reg;
        stat_next    = stat_reg;
        cmp_next     = cmp_reg;
        level_next   = level_reg;
        refresh      = 1'b0;
        lvl          = 1'b0;
        res          = '0;

        unique case (lcdsm_pkg::op_t'(opcode))
            lcdsm_pkg::OP_TICK:
            begin
                if (running_reg)
                begin
                    dot_next = dot_inc;
                    unique case (mode_reg)
                        lcdsm_pkg::MODE_HBLANK, lcdsm_pkg::MODE_VBLANK:
                        begin
                            if (dot_ext >= LINE_END_T)
                            begin
                                dot_next  = '0;
                                line_next = line_wrap;
                                if (line_wrap == VBL_LINE)
                                begin
                                    mode_next      = lcdsm_pkg::MODE_VBLANK;
                                    res.vblank_irq = 1'b1;
                                    res.frame_done = 1'b1;
                                end
                                else if (line_wrap < VBL_LINE)
                                begin
                                    mode_next = lcdsm_pkg::MODE_OAM;
                                end
                                stat_next[1:0] = mode_next;
                                stat_next[lcdsm_pkg::STAT_LYC_FLAG] = (cmp_reg == line_wrap);
                                refresh = 1'b1;
                            end
                        end
                        lcdsm_pkg::MODE_OAM:
                        begin
                            if (dot_ext >= SCAN_END_T)
                            begin
                                mode_next      = lcdsm_pkg::MODE_DRAW;
                                stat_next[1:0] = lcdsm_pkg::MODE_DRAW;
                                refresh        = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (dot_ext >= DRAW_END_T)
                            begin
                                mode_next      = lcdsm_pkg::MODE_HBLANK;
                                stat_next[1:0] = lcdsm_pkg::MODE_HBLANK;
                                refresh        = 1'b1;
                            end
                            else if (dot_ext >= PIX_T)
                            begin
                                res.pixel_valid = 1'b1;
                                res.pixel_x     = pix_diff[BYTE_W-1:0];
                                res.pixel_y     = line_reg;
                            end
                        end
                    endcase
                end
            end
            lcdsm_pkg::OP_CTRL:
            begin
                if (!ctrl_reg[lcdsm_pkg::CTRL_ENABLE] && write_data[lcdsm_pkg::CTRL_ENABLE])
                begin
                    running_next   = 1'b1;
                    mode_next      = lcdsm_pkg::MODE_OAM;
                    stat_next[1:0] = lcdsm_pkg::MODE_OAM;
                    refresh        = 1'b1;
                end
                else if (ctrl_reg[lcdsm_pkg::CTRL_ENABLE] &&
                         !write_data[lcdsm_pkg::CTRL_ENABLE])
                begin
                    // display off: mode is kept, status mode bits read as hblank
                    running_next   = 1'b0;
                    stat_next[1:0] = '0;
                    dot_next       = '0;
                    line_next      = '0;
                    level_next     = 1'b0;
                    res.frame_done = 1'b1;
                end
                ctrl_next = write_data;
            end
            lcdsm_pkg::OP_STAT:
            begin
                stat_next = {write_data[BYTE_W-1:3], stat_reg[2:0]};
                refresh   = 1'b1;
            end
            default:
            begin
                cmp_next = write_data;
                refresh  = 1'b1;
            end
        endcase

        if (refresh)
        begin
            lvl          = level_of(stat_next, cmp_next, line_next, mode_next);
            res.stat_irq = lvl && !level_reg;
            level_next   = lvl;
        end

        res.mode_now    = mode_next;
        res.line_now    = line_next;
        res.status_byte = stat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            mode_reg    <= lcdsm_pkg::MODE_HBLANK;
            dot_reg     <= '0;
            line_reg    <= '0;
            ctrl_reg    <= '0;
            stat_reg    <= '0;
            cmp_reg     <= '0;
            level_reg   <= 1'b0;
        end
        else if (fire)
        begin
            running_reg <= running_next;
            mode_reg    <= mode_next;
            dot_reg     <= dot_next;
            line_reg    <= line_next;
            ctrl_reg    <= ctrl_next;
            stat_reg    <= stat_next;
            cmp_reg     <= cmp_next;
            level_reg   <= level_next;
        end
    end

endmodule

/* src/lcd_scanline_mode_timer_unit.sv */
// Scanline mode timer: each command beat is a dot tick or a write to the
// control, status or line-compare register, and each produces exactly one
// result beat carrying mode, line, status, the STAT / vblank / frame pulses
// and the pixel coordinate due on that dot. Throughput is one beat per clock
// with no bubbles while the result side is ready; a beat is registered on
// entry in the command register, processed by the state-update logic once
// the result register has room, and presented from the result register.
// Back pressure on the result side holds the command register, which keeps
// taking beats while it has room. No clearing pass follows reset.
`include "lcd_scanline_mode_timer_unit_defines.svh"

module lcd_scanline_mode_timer_unit #(
    parameter int LINE_DOTS      = lcdsm_pkg::DEF_LINE_DOTS,
    parameter int SCAN_DOTS      = lcdsm_pkg::DEF_SCAN_DOTS,
    parameter int DRAW_DOTS      = lcdsm_pkg::DEF_DRAW_DOTS,
    parameter int DRAW_LEAD_DOTS = lcdsm_pkg::DEF_DRAW_LEAD_DOTS,
    parameter int VISIBLE_LINES  = lcdsm_pkg::DEF_VISIBLE_LINES,
    parameter int BLANK_LINES    = lcdsm_pkg::DEF_BLANK_LINES
) (
    input  logic          clk,
    input  logic          rst_n,
    lcdsm_cmd_if.sink     cmd,
    lcdsm_res_if.source   result
);

    // command register
    logic                         cmd_valid_reg, cmd_valid_next;
    logic [lcdsm_pkg::OP_W-1:0]   op_reg;
    logic [lcdsm_pkg::BYTE_W-1:0] data_reg;

    // result register
    logic                         res_valid_reg, res_valid_next;
    lcdsm_pkg::result_t           res_reg;
    lcdsm_pkg::result_t           res_calc;

    logic res_room;   // result register free or emptying this cycle
    logic fire;       // command beat goes through the timer this cycle
    logic cmd_take;

    // terms for the checks at the end
    logic pix_beat;
    logic vbl_beat;
    logic vbl_ok;
    logic mode_ok;

    assign res_room   = !res_valid_reg || result.ready;
    assign fire       = cmd_valid_reg && res_room;
    assign cmd.ready  = !cmd_valid_reg || fire;
    assign cmd_take   = cmd.valid && cmd.ready;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd_take)
            cmd_valid_next = 1'b1;
        else if (fire)
            cmd_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (fire)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg   <= cmd.opcode;
            data_reg <= cmd.write_data;
        end
        if (fire)
            res_reg <= res_calc;
    end

    lcdsm_core #(
        .LINE_DOTS      (LINE_DOTS),
        .SCAN_DOTS      (SCAN_DOTS),
        .DRAW_DOTS      (DRAW_DOTS),
        .DRAW_LEAD_DOTS (DRAW_LEAD_DOTS),
        .VISIBLE_LINES  (VISIBLE_LINES),
        .BLANK_LINES    (BLANK_LINES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .opcode     (op_reg),
        .write_data (data_reg),
        .res        (res_calc)
    );

    assign result.valid       = res_valid_reg;
    assign result.mode_now    = res_reg.mode_now;
    assign result.line_now    = res_reg.line_now;
    assign result.status_byte = res_reg.status_byte;
    assign result.stat_irq    = res_reg.stat_irq;
    assign result.vblank_irq  = res_reg.vblank_irq;
    assign result.frame_done  = res_reg.frame_done;
    assign result.pixel_valid = res_reg.pixel_valid;
    assign result.pixel_x     = res_reg.pixel_x;
    assign result.pixel_y     = res_reg.pixel_y;

    assign pix_beat = result.valid && result.pixel_valid;
    assign vbl_beat = result.valid && result.vblank_irq;
    assign vbl_ok   = result.frame_done && (result.line_now == 8'(VISIBLE_LINES)) &&
                      (result.mode_now == lcdsm_pkg::MODE_VBLANK);
    assign mode_ok  = (result.status_byte[1:0] == result.mode_now) ||
                      (result.status_byte[1:0] == 2'd0);

    // pixels are only due while drawing
    `LCDSM_ASSERT_IMP(a_pix_in_draw, clk, rst_n, pix_beat, result.mode_now == lcdsm_pkg::MODE_DRAW)
    // vblank pulse comes with frame done on the first blank line
    `LCDSM_ASSERT_IMP(a_vbl_frame, clk, rst_n, vbl_beat, vbl_ok)
    // status mode bits track the mode, or read hblank once disabled
    `LCDSM_ASSERT_IMP(a_stat_mode, clk, rst_n, result.valid, mode_ok)
    // a processed beat always lands in the result register
    `LCDSM_ASSERT_NXT(a_fire_lands, clk, rst_n, fire, result.valid)

endmodule

/* sim/tb.sv */
// Testbench for the scanline mode timer. Command beats (dot ticks and
// control, status and line-compare writes) go in; one result beat comes out
// for each, and it is checked field by field against a local timing model.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Timing at the default parameter set, which is what the block is built with
    localparam int LINE_DOTS       = lcdsm_pkg::DEF_LINE_DOTS;
    localparam int SCAN_END        = lcdsm_pkg::DEF_SCAN_DOTS;
    localparam int DRAW_END        = lcdsm_pkg::DEF_SCAN_DOTS + lcdsm_pkg::DEF_DRAW_DOTS;
    localparam int PIXEL_START     = lcdsm_pkg::DEF_SCAN_DOTS + lcdsm_pkg::DEF_DRAW_LEAD_DOTS;
    localparam int VISIBLE         = lcdsm_pkg::DEF_VISIBLE_LINES;
    localparam int LINES_PER_FRAME = lcdsm_pkg::DEF_VISIBLE_LINES + lcdsm_pkg::DEF_BLANK_LINES;
    // a whole line and the next scan and draw, flat out
    localparam int WALK_DOTS       = LINE_DOTS + DRAW_END;

    localparam int RANDOM_BEATS    = 900;
    localparam int HOLD_OFF_CYCLES = 200;
    // Cycles with no beat on either side before the run is declared hung.
    // Longest legal quiet stretch is the result hold-off above.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Margin for stragglers after the expected results have drained
    localparam int DRAIN_CYCLES    = 10;

    logic clk;
    logic rst_n;

    lcdsm_cmd_if cmd_bus ();
    lcdsm_res_if res_bus ();

    lcd_scanline_mode_timer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus.sink),
        .result (res_bus.source)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Timing model. Updated once per accepted command beat, in the same
    // process that checks results, so nothing hangs on event ordering.
    // ------------------------------------------------------------------
    logic             lcd_on;
    lcdsm_pkg::mode_t lcd_mode;   // kept across a disable, only the status copy clears
    logic [8:0]       dot_pos;
    logic [7:0]       line_pos;
    logic [7:0]       ctrl_q;
    logic [7:0]       stat_q;
    logic [7:0]       lyc_q;
    logic             stat_line;  // combined STAT request level
    logic             stat_rise;  // pulses gathered over one beat
    logic             vbl_hit;
    logic             frame_hit;

    lcdsm_pkg::result_t expected_results[$];
    int                 mismatches;
    int                 quiet_cycles;

    // Knobs shared with the stimulus: per-beat idle range on each side, and
    // a one-shot long hold-off for the result side.
    int      tx_gap_max;
    int      rx_gap_max;
    int      rx_hold_cycles;

    // Level is the OR of the compare match and the enable for the current
    // mode (draw has no enable); a rise from zero raises the interrupt.
    function automatic void refresh_stat_line();
        logic want;
        want = (stat_q[lcdsm_pkg::STAT_LYC_EN] && lyc_q == line_pos)
            || (lcd_mode == lcdsm_pkg::MODE_HBLANK && stat_q[lcdsm_pkg::STAT_HBL_EN])
            || (lcd_mode == lcdsm_pkg::MODE_VBLANK && stat_q[lcdsm_pkg::STAT_VBL_EN])
            || (lcd_mode == lcdsm_pkg::MODE_OAM && stat_q[lcdsm_pkg::STAT_OAM_EN]);
        if (!stat_line && want)
            stat_rise = 1'b1;
        stat_line = want;
    endfunction

    function automatic void switch_mode(input lcdsm_pkg::mode_t m);
        lcd_mode = m;
        stat_q[1:0] = m;
        refresh_stat_line();
    endfunction

    function automatic lcdsm_pkg::result_t predict_beat(input lcdsm_pkg::op_t op,
                                                        input logic [7:0] data);
        lcdsm_pkg::result_t r;
        r = '0;
        stat_rise = 1'b0;
        vbl_hit = 1'b0;
        frame_hit = 1'b0;
        case (op)
            lcdsm_pkg::OP_TICK:
            begin
                // a tick with the display off changes nothing
                if (lcd_on)
                begin
                    dot_pos = dot_pos + 9'd1;
                    case (lcd_mode)
                        lcdsm_pkg::MODE_HBLANK, lcdsm_pkg::MODE_VBLANK:
                        begin
                            if (dot_pos >= LINE_DOTS)
                            begin
                                dot_pos = '0;
                                line_pos = 8'((int'(line_pos) + 1) % LINES_PER_FRAME);
                                if (line_pos == VISIBLE)
                                begin
                                    switch_mode(lcdsm_pkg::MODE_VBLANK);
                                    vbl_hit = 1'b1;
                                    frame_hit = 1'b1;
                                end
                                else if (line_pos < VISIBLE)
                                    switch_mode(lcdsm_pkg::MODE_OAM);
                                // compare flag only moves at the start of a line
                                stat_q[lcdsm_pkg::STAT_LYC_FLAG] = (lyc_q == line_pos);
                                refresh_stat_line();
                            end
                        end
                        lcdsm_pkg::MODE_OAM:
                        begin
                            if (dot_pos >= SCAN_END)
                                switch_mode(lcdsm_pkg::MODE_DRAW);
                        end
                        default:
                        begin
                            if (dot_pos >= DRAW_END)
                                switch_mode(lcdsm_pkg::MODE_HBLANK);
                            else if (dot_pos >= PIXEL_START)
                            begin
                                r.pixel_valid = 1'b1;
                                r.pixel_x = 8'(int'(dot_pos) - PIXEL_START);
                                r.pixel_y = line_pos;
                            end
                        end
                    endcase
                end
            end
            lcdsm_pkg::OP_CTRL:
            begin
                if (!ctrl_q[lcdsm_pkg::CTRL_ENABLE] && data[lcdsm_pkg::CTRL_ENABLE])
                begin
                    // enable: scan starts at the current line and dot
                    lcd_on = 1'b1;
                    switch_mode(lcdsm_pkg::MODE_OAM);
                end
                else if (ctrl_q[lcdsm_pkg::CTRL_ENABLE] && !data[lcdsm_pkg::CTRL_ENABLE])
                begin
                    // disable: counters and level cleared, frame strobe
                    lcd_on = 1'b0;
                    stat_q[1:0] = 2'b00;
                    frame_hit = 1'b1;
                    dot_pos = '0;
                    stat_line = 1'b0;
                    line_pos = '0;
                end
                ctrl_q = data;
            end
            lcdsm_pkg::OP_STAT:
            begin
                // mode bits and compare flag are read-only
                stat_q = {data[7:3], stat_q[2:0]};
                refresh_stat_line();
            end
            default:
            begin
                lyc_q = data;
                refresh_stat_line();
            end
        endcase
        r.mode_now = lcd_mode;
        r.line_now = line_pos;
        r.status_byte = stat_q;
        r.stat_irq = stat_rise;
        r.vblank_irq = vbl_hit;
        r.frame_done = frame_hit;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: predicts on every accepted command beat, checks every
    // accepted result beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        lcdsm_pkg::result_t want;
        lcdsm_pkg::result_t pred;
        logic               cmd_beat;
        logic               res_beat;
        if (!rst_n)
        begin
            lcd_on = 1'b0;
            lcd_mode = lcdsm_pkg::MODE_HBLANK;
            dot_pos = '0;
            line_pos = '0;
            ctrl_q = '0;
            stat_q = '0;
            lyc_q = '0;
            stat_line = 1'b0;
            expected_results.delete();
            quiet_cycles <= 0;
        end
        else
        begin
            cmd_beat = cmd_bus.valid && cmd_bus.ready;
            res_beat = res_bus.valid && res_bus.ready;
            if (cmd_beat)
            begin
                pred = predict_beat(lcdsm_pkg::op_t'(cmd_bus.opcode), cmd_bus.write_data);
                expected_results = {expected_results, pred};
            end
            if (res_beat)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat arrived with nothing outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("mode_now", want.mode_now, res_bus.mode_now);
                    check_field("line_now", want.line_now, res_bus.line_now);
                    check_field("status_byte", want.status_byte, res_bus.status_byte);
                    check_field("stat_irq", want.stat_irq, res_bus.stat_irq);
                    check_field("vblank_irq", want.vblank_irq, res_bus.vblank_irq);
                    check_field("frame_done", want.frame_done, res_bus.frame_done);
                    check_field("pixel_valid", want.pixel_valid, res_bus.pixel_valid);
                    check_field("pixel_x", want.pixel_x, res_bus.pixel_x);
                    check_field("pixel_y", want.pixel_y, res_bus.pixel_y);
                end
            end
            quiet_cycles <= (cmd_beat || res_beat) ? 0 : quiet_cycles + 1;
        end
    end

    // Hang detector: too long without a beat on either side
    initial
    begin
        do
            @(posedge clk);
        while (quiet_cycles < WATCHDOG_LIMIT);
        $display("** lcd_scanline_mode_timer_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side. Draws an idle count per beat; ready is only dropped when
    // a pause is actually wanted, so back-to-back beats keep it high.
    // ------------------------------------------------------------------
    initial
    begin
        int pause;
        res_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                pause = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
                pause = $urandom_range(rx_gap_max);
            if (pause > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_bus.valid);
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // One command beat. Valid is lowered only for an idle gap, never
    // dropped and re-raised in the same step.
    task automatic send_beat(input lcdsm_pkg::op_t op, input logic [7:0] data);
        int gap;
        gap = $urandom_range(tx_gap_max);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.opcode <= op;
        cmd_bus.write_data <= data;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
    endtask

    // Compare values lean towards the lines the traffic actually visits
    function automatic logic [7:0] pick_compare_line();
        case ($urandom_range(3))
            0, 1:    return 8'($urandom_range(7));
            2:       return 8'($urandom_range(LINES_PER_FRAME - 1));
            default: return 8'($urandom);
        endcase
    endfunction

    // Register extremes, each opcode, ticks while off, read-only status
    // bits, enable / disable / plain control writes and compare matches.
    task automatic test_register_extremes();
        tx_gap_max = 0;
        rx_gap_max = 0;
        send_beat(lcdsm_pkg::OP_TICK, 8'h00);   // display off: nothing moves
        send_beat(lcdsm_pkg::OP_TICK, 8'hFF);
        send_beat(lcdsm_pkg::OP_STAT, 8'hFF);   // low three bits must stay put
        send_beat(lcdsm_pkg::OP_STAT, 8'h00);
        send_beat(lcdsm_pkg::OP_LYC, 8'hFF);
        send_beat(lcdsm_pkg::OP_LYC, 8'h00);
        send_beat(lcdsm_pkg::OP_STAT, 8'h40);   // compare match on line 0 raises STAT
        send_beat(lcdsm_pkg::OP_CTRL, 8'h7F);   // enable bit clear: byte stored only
        send_beat(lcdsm_pkg::OP_STAT, 8'h20);
        send_beat(lcdsm_pkg::OP_CTRL, 8'hFF);   // enable, straight into OAM scan
        send_beat(lcdsm_pkg::OP_CTRL, 8'h80);   // still enabled: stored only
        send_beat(lcdsm_pkg::OP_TICK, 8'h5A);
        send_beat(lcdsm_pkg::OP_TICK, 8'hA5);
        send_beat(lcdsm_pkg::OP_TICK, 8'h00);
        send_beat(lcdsm_pkg::OP_CTRL, 8'h00);   // disable: frame strobe, counters cleared
        send_beat(lcdsm_pkg::OP_TICK, 8'hFF);
        send_beat(lcdsm_pkg::OP_STAT, 8'h08);   // level follows the mode kept while off
        send_beat(lcdsm_pkg::OP_CTRL, 8'h80);
        send_beat(lcdsm_pkg::OP_LYC, 8'h01);
        send_beat(lcdsm_pkg::OP_STAT, 8'h78);
        send_beat(lcdsm_pkg::OP_TICK, 8'h00);
    endtask

    // Mostly ticks so that lines actually get walked, with register writes
    // and the odd disable mixed in; idling is switched on and off in runs.
    task automatic test_random_traffic();
        int         roll;
        logic [7:0] data;
        send_beat(lcdsm_pkg::OP_CTRL, 8'h80 | 8'($urandom_range(127)));
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 100 == 0)
            begin
                tx_gap_max = $urandom_range(1) ? 19 : 0;
                rx_gap_max = $urandom_range(1) ? 19 : 0;
            end
            roll = $urandom_range(99);
            if (roll < 84)
                send_beat(lcdsm_pkg::OP_TICK, 8'($urandom));
            else if (roll < 92)
                send_beat(lcdsm_pkg::OP_STAT, 8'($urandom));
            else if (roll < 97)
                send_beat(lcdsm_pkg::OP_LYC, pick_compare_line());
            else
            begin
                data = 8'($urandom);
                if ($urandom_range(9) != 0)
                    data[lcdsm_pkg::CTRL_ENABLE] = 1'b1;
                send_beat(lcdsm_pkg::OP_CTRL, data);
            end
        end
    endtask

    // Result side holds off for a long stretch while ticks keep coming, so
    // the pipeline fills and the command side has to stall.
    task automatic test_result_backpressure();
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        repeat (40) send_beat(lcdsm_pkg::OP_TICK, 8'($urandom));
    endtask

    // From line 0 through a whole line and on into the next draw phase:
    // scan, draw, hblank and the line change, with all STAT sources on at
    // first and the odd status or compare rewrite on the way.
    task automatic test_line_walk();
        tx_gap_max = 0;
        rx_gap_max = 0;
        send_beat(lcdsm_pkg::OP_CTRL, 8'h00);
        send_beat(lcdsm_pkg::OP_CTRL, 8'h80 | 8'($urandom_range(127)));
        send_beat(lcdsm_pkg::OP_STAT, 8'h78);
        send_beat(lcdsm_pkg::OP_LYC, 8'($urandom_range(3)));
        for (int n = 0; n < WALK_DOTS; n++)
        begin
            if ($urandom_range(999) == 0)
                send_beat(lcdsm_pkg::OP_STAT, 8'($urandom));
            else if ($urandom_range(999) == 0)
                send_beat(lcdsm_pkg::OP_LYC, 8'($urandom_range(3)));
            // mostly flat out, with the occasional gap on either side
            tx_gap_max = ($urandom_range(63) == 0) ? 19 : 0;
            rx_gap_max = ($urandom_range(63) == 0) ? 19 : 0;
            send_beat(lcdsm_pkg::OP_TICK, 8'($urandom));
        end
    endtask

    initial
    begin
        mismatches = 0;
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold_cycles = 0;
        rst_n <= 1'b0;
        cmd_bus.valid <= 1'b0;
        cmd_bus.opcode <= lcdsm_pkg::OP_TICK;
        cmd_bus.write_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_extremes();
        test_random_traffic();
        test_result_backpressure();
        test_line_walk();

        cmd_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** lcd_scanline_mode_timer_unit: PASSED **");
        else
            $display("** lcd_scanline_mode_timer_unit: FAILED **");
        $finish;
    end

endmodule
